[hw/rtl/flrl_pkg.sv]
package flrl_pkg;

	localparam int DEF_REGION_BYTES = 1024;
	localparam int DEF_SECTOR_BYTES = 512;
	localparam int DEF_EMPTY_RUN    = 32;

	localparam logic [7:0] HDR_MARK = 8'hAA;
	localparam logic [7:0] ERASED   = 8'hFF;
	localparam logic [7:0] ZERO     = 8'h00;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_CHECK = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_HDR = 2'd1;
	localparam logic [1:0] ST_BAD_SUM = 2'd2;
	localparam logic [1:0] ST_NO_DATA = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_in;
		logic [7:0] byte_index;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [1:0] status;
		logic       committed;
		logic [7:0] stored_length;
	} out_word_t;

	typedef struct packed {
		logic accept;
		logic out_free;
	} seq_in_t;

	typedef struct packed {
		logic ready;
		logic load;
	} seq_out_t;

endpackage

[hw/rtl/flrl_ctrl.sv]
module flrl_ctrl import flrl_pkg::*; #(
	parameter int REGION_BYTES = DEF_REGION_BYTES,
	parameter int SECTOR_BYTES = DEF_SECTOR_BYTES,
	parameter int EMPTY_RUN    = DEF_EMPTY_RUN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  seq_in_t    hs,
	input  in_word_t   item,
	input  logic [7:0] record_length,
	output seq_out_t   st,
	output out_word_t  res
);

	localparam int AW = $clog2(REGION_BYTES);
	localparam int PW = $clog2(REGION_BYTES + 520);
	localparam int EW = $clog2(REGION_BYTES + 1);
	localparam int ERASE_BYTES = (REGION_BYTES / SECTOR_BYTES) * SECTOR_BYTES;
	localparam logic [PW-1:0] R_P   = PW'(REGION_BYTES);
	localparam logic [PW:0]   R_P1  = (PW+1)'(REGION_BYTES);
	localparam logic [EW-1:0] LIM_F = EW'(REGION_BYTES - 1);
	localparam logic [EW-1:0] LIM_E = EW'(ERASE_BYTES - 1);
	localparam logic [AW-1:0] P_LAST = AW'(REGION_BYTES - 1);
	localparam logic [8:0]    RUN_N  = 9'(EMPTY_RUN);
	localparam logic [PW-1:0] RUN_B  = PW'(EMPTY_RUN - 1);

	localparam logic [3:0] S_IDLE = 4'd0,  S_DISP = 4'd1,  S_SCAN_RD = 4'd2,
		S_SCAN_CHK = 4'd3, S_SCAN_LEN = 4'd4, S_ERASE = 4'd5, S_P_ZERO = 4'd6,
		S_P_HDR = 4'd7, S_P_LENW = 4'd8, S_P_LEN = 4'd9, S_P_DATA = 4'd10,
		S_P_CKS = 4'd11, S_C_HDR = 4'd12, S_C_LEN = 4'd13, S_C_SUM = 4'd14,
		S_DONE = 4'd15;

	logic [7:0] mem [REGION_BYTES];
	logic [7:0] rdata;
	logic       oor_q;
	logic [7:0] rdv;

	logic [3:0]    state_q, ret_q;
	logic          full_q, pos_known_q, pv_q, wrap_q;
	logic [EW-1:0] ers_q;
	logic [PW-1:0] wp_q, pstart_q, ptr_q;
	logic [8:0]    ps_q, i_q, ffs_q;
	logic [7:0]    cnt_q, psum_q, plen_q, len_q, csum_q;
	logic [AW-1:0] p_q;
	in_word_t      it_q;
	out_word_t     res_q;

	logic          we;
	logic [PW-1:0] waddr, raddr;
	logic [7:0]    wdata;
	logic [PW:0]   zsum;
	logic [8:0]    ffs_n;

	assign rdv   = oor_q ? ERASED : rdata;
	assign zsum  = {1'b0, wp_q} + (PW+1)'(i_q);
	assign ffs_n = ffs_q + 9'(rdv == ERASED);

	// memory port
	always_comb begin
		we    = 1'b0;
		waddr = wp_q;
		wdata = ZERO;
		raddr = wp_q;
		unique case (state_q)
			S_ERASE: begin
				we    = 1'b1;
				waddr = PW'(ers_q);
				wdata = ERASED;
			end
			S_P_ZERO: begin
				we    = zsum >= (PW+1)'(ps_q);
				waddr = PW'(zsum - (PW+1)'(ps_q));
			end
			S_P_HDR:  begin we = 1'b1; wdata = HDR_MARK; end
			S_P_LENW: begin we = 1'b1; wdata = len_q; end
			S_P_DATA: begin we = 1'b1; wdata = it_q.data_in; end
			S_P_CKS:  begin we = 1'b1; wdata = psum_q; end
			S_DISP: begin
				unique case (it_q.cmd)
					CMD_PUSH:  raddr = wp_q - PW'(cnt_q) - PW'(1);
					CMD_CHECK: raddr = wp_q - PW'(ps_q);
					default:   raddr = pstart_q + PW'(it_q.byte_index);
				endcase
			end
			S_SCAN_RD:  raddr = PW'(p_q);
			S_SCAN_CHK: raddr = PW'(p_q) + PW'(1);
			S_C_HDR:    raddr = ptr_q + PW'(1);
			S_C_LEN:    raddr = ptr_q + PW'(2);
			S_C_SUM:    raddr = ptr_q + PW'(3) + PW'(i_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we && waddr < R_P) mem[waddr[AW-1:0]] <= wdata;
		rdata <= mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ERASE;
			ret_q       <= S_IDLE;
			full_q      <= 1'b1;
			ers_q       <= '0;
			pos_known_q <= 1'b0;
			pv_q        <= 1'b0;
			wrap_q      <= 1'b0;
			wp_q        <= '0;
			pstart_q    <= '0;
			ptr_q       <= '0;
			ps_q        <= '0;
			i_q         <= '0;
			ffs_q       <= '0;
			cnt_q       <= '0;
			psum_q      <= '0;
			plen_q      <= '0;
			len_q       <= '0;
			csum_q      <= '0;
			p_q         <= '0;
			it_q        <= '0;
			res_q       <= '0;
			oor_q       <= 1'b0;
		end else begin
			oor_q <= raddr >= R_P;
			unique case (state_q)
				S_IDLE: begin
					if (hs.accept) begin
						it_q  <= item;
						res_q <= '0;
						if (item.cmd == CMD_NOP) state_q <= S_DONE;
						else state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (!pos_known_q) begin
						p_q     <= '0;
						ffs_q   <= '0;
						state_q <= S_SCAN_RD;
					end else begin
						unique case (it_q.cmd)
							CMD_PUSH: begin
								pv_q <= 1'b0;
								if (cnt_q == 8'd0) begin
									len_q   <= record_length;
									i_q     <= '0;
									wrap_q  <= 1'b0;
									state_q <= (ps_q == 9'd0) ? S_P_HDR : S_P_ZERO;
								end else begin
									state_q <= S_P_LEN;
								end
							end
							CMD_CHECK: begin
								pv_q <= 1'b0;
								if (wp_q < PW'(ps_q)) begin
									res_q.status <= ST_BAD_HDR;
									state_q      <= S_DONE;
								end else begin
									ptr_q   <= wp_q - PW'(ps_q);
									state_q <= S_C_HDR;
								end
							end
							default: begin
								if (!pv_q || it_q.byte_index >= plen_q) begin
									res_q.status <= ST_NO_DATA;
									state_q      <= S_DONE;
								end else begin
									// data byte arrives next cycle
									state_q <= S_P_LEN;
								end
							end
						endcase
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (ffs_n >= RUN_N) begin
						wp_q        <= PW'(p_q) - RUN_B;
						pos_known_q <= 1'b1;
						state_q     <= S_DISP;
					end else if (rdv == HDR_MARK) begin
						state_q <= S_SCAN_LEN;
					end else if (p_q == P_LAST) begin
						wp_q        <= '0;
						pos_known_q <= 1'b1;
						full_q      <= 1'b0;
						ers_q       <= '0;
						ret_q       <= S_DISP;
						state_q     <= S_ERASE;
					end else begin
						p_q   <= p_q + AW'(1);
						ffs_q <= ffs_n;
					end
				end
				S_SCAN_LEN: begin
					wp_q        <= PW'(p_q) + PW'(rdv) + PW'(3);
					ps_q        <= 9'(rdv) + 9'd3;
					pos_known_q <= 1'b1;
					state_q     <= S_DISP;
				end
				S_ERASE: begin
					ers_q <= ers_q + EW'(1);
					if (ers_q == (full_q ? LIM_F : LIM_E)) begin
						ers_q   <= '0;
						state_q <= ret_q;
					end
				end
				S_P_ZERO: begin
					i_q <= i_q + 9'd1;
					if (i_q == ps_q - 9'd1) state_q <= S_P_HDR;
				end
				S_P_HDR: begin
					wp_q    <= wp_q + PW'(1);
					state_q <= S_P_LENW;
				end
				S_P_LENW: begin
					ps_q <= 9'(len_q) + 9'd3;
					if (!wrap_q && ({1'b0, wp_q} + (PW+1)'(len_q) + (PW+1)'(5)) > R_P1) begin
						wrap_q  <= 1'b1;
						wp_q    <= '0;
						full_q  <= 1'b0;
						ers_q   <= '0;
						ret_q   <= S_P_HDR;
						state_q <= S_ERASE;
					end else begin
						wrap_q  <= 1'b0;
						wp_q    <= wp_q + PW'(1);
						psum_q  <= 8'd0;
						state_q <= (len_q == 8'd0) ? S_P_CKS : S_P_DATA;
					end
				end
				S_P_LEN: begin
					// push: length byte of the open record; read: the data byte
					if (it_q.cmd == CMD_PUSH) begin
						len_q   <= rdv;
						state_q <= S_P_DATA;
					end else begin
						res_q.data_out <= rdv;
						state_q        <= S_DONE;
					end
				end
				S_P_DATA: begin
					wp_q   <= wp_q + PW'(1);
					psum_q <= psum_q + it_q.data_in;
					cnt_q  <= cnt_q + 8'd1;
					if ({1'b0, cnt_q} + 9'd1 >= {1'b0, len_q}) state_q <= S_P_CKS;
					else state_q <= S_DONE;
				end
				S_P_CKS: begin
					wp_q            <= wp_q + PW'(1);
					cnt_q           <= 8'd0;
					psum_q          <= 8'd0;
					res_q.committed <= 1'b1;
					state_q         <= S_DONE;
				end
				S_C_HDR: begin
					if (rdv != HDR_MARK) begin
						res_q.status <= ST_BAD_HDR;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_C_LEN;
					end
				end
				S_C_LEN: begin
					res_q.stored_length <= rdv;
					len_q   <= rdv;
					csum_q  <= 8'd0;
					i_q     <= 9'd0;
					state_q <= S_C_SUM;
				end
				S_C_SUM: begin
					if (i_q == {1'b0, len_q}) begin
						if (csum_q == rdv) begin
							pv_q     <= 1'b1;
							pstart_q <= ptr_q + PW'(2);
							plen_q   <= len_q;
							ps_q     <= 9'(len_q) + 9'd3;
						end else begin
							res_q.status <= ST_BAD_SUM;
						end
						state_q <= S_DONE;
					end else begin
						csum_q <= csum_q + rdv;
						i_q    <= i_q + 9'd1;
					end
				end
				S_DONE: if (hs.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign st.ready = state_q == S_IDLE;
	assign st.load  = state_q == S_DONE && hs.out_free;
	assign res      = res_q;

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !we) else $error("write while idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st.load |=> state_q == S_IDLE) else $error("load without return to idle");
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(pos_known_q)) else $error("position lost");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_P_CKS |=> cnt_q == 8'd0) else $error("push count not cleared");

endmodule

[hw/rtl/flash_record_log_store_core.sv]
// Record log store: keeps records (0xAA header, length byte, data bytes,
// additive checksum) in an internal byte store that is scanned once, on the
// first push, check or read after reset, to find the write position. After
// reset the whole store is cleared to 0xFF while item words are refused;
// configuration words are always taken. Every item makes one result word.
// The byte memory is walked one byte at a time: a read fetches the data byte,
// the first byte of a record adds the zeroing of the previous record, a check
// sums the stored record, the first access adds a scan of the store, and a
// wrap adds an erase of the store.
// record_length is taken into the next record header only; write it while idle.
module flash_record_log_store_core import flrl_pkg::*; #(
	parameter int REGION_BYTES = DEF_REGION_BYTES,
	parameter int SECTOR_BYTES = DEF_SECTOR_BYTES,
	parameter int EMPTY_RUN    = DEF_EMPTY_RUN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_word_t   item,
	output logic       result_valid,
	input  logic       result_ready,
	output out_word_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic [7:0] reclen_q;
	logic       rvalid_q;
	out_word_t  result_q;
	out_word_t  res;
	seq_in_t    hs;
	seq_out_t   st;

	// config register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) reclen_q <= 8'd1;
		else if (cfg_valid) reclen_q <= cfg_data;
	end

	// accept only when the sequencer is idle
	assign item_ready  = st.ready;
	assign hs.accept   = item_valid && st.ready;
	// output register frees when empty or taken this cycle
	assign hs.out_free = !rvalid_q || result_ready;

	flrl_ctrl #(
		.REGION_BYTES(REGION_BYTES),
		.SECTOR_BYTES(SECTOR_BYTES),
		.EMPTY_RUN   (EMPTY_RUN)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.hs           (hs),
		.item         (item),
		.record_length(reclen_q),
		.st           (st),
		.res          (res)
	);

	// hold result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			result_q <= '0;
		end else if (st.load) begin
			rvalid_q <= 1'b1;
			result_q <= res;
		end else if (result_ready) begin
			rvalid_q <= 1'b0;
		end
	end

	assign result_valid = rvalid_q;
	assign result       = result_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
	import flrl_pkg::*;

	localparam int REGION   = DEF_REGION_BYTES;
	localparam int SECTOR   = DEF_SECTOR_BYTES;
	localparam int RUN_FF   = DEF_EMPTY_RUN;
	localparam int WDOG_MAX = 20000;
	localparam int DIR_ROWS = 14;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_word_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_word_t result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [7:0] cfg_data = 8'd0;

	// Shadow of the block: byte store, log pointers, pull window, length register.
	logic [7:0] mem [REGION];
	int         wpos;
	bit         pos_found;
	int         last_span;
	int         fill_cnt;
	logic [7:0] fill_sum;
	bit         window_ok;
	int         window_base;
	int         window_len;
	logic [7:0] rec_len;

	out_word_t  pending_words [$];
	// Words expected verbatim from the directed table (mask set where typed in).
	out_word_t  typed_word [$];
	bit         typed_flag [$];

	int  n_fail = 0;
	int  wdog = 0;
	bit  all_sent = 1'b0;

	flash_record_log_store_core u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] mem_rd(int a);
		if (a < 0 || a >= REGION) return ERASED;
		return mem[a];
	endfunction

	function automatic void mem_wr(int a, logic [7:0] v);
		if (a >= 0 && a < REGION) mem[a] = v;
	endfunction

	function automatic void wipe_store();
		for (int i = 0; i < (REGION / SECTOR) * SECTOR; i++) mem[i] = ERASED;
	endfunction

	// Find the log position: a run of erased bytes or the first header mark.
	function automatic void locate_record();
		int ffs;
		ffs = 0;
		for (int p = 0; p < REGION; p++) begin
			if (mem[p] == ERASED) ffs++;
			if (ffs >= RUN_FF) begin
				wpos = p - (RUN_FF - 1);
				pos_found = 1'b1;
				return;
			end
			if (mem[p] == HDR_MARK) begin
				wpos = p + int'(mem_rd(p + 1)) + 3;
				last_span = int'(mem_rd(p + 1)) + 3;
				pos_found = 1'b1;
				return;
			end
		end
		wpos = 0;
		wipe_store();
		pos_found = 1'b1;
	endfunction

	function automatic void append_byte(logic [7:0] v);
		mem_wr(wpos, v);
		wpos++;
	endfunction

	function automatic bit push_byte(logic [7:0] din);
		int len;
		if (fill_cnt == 0) begin
			len = int'(rec_len);
			// Zero out the previous record before opening a new one.
			for (int i = 0; i < last_span; i++)
				if (wpos + i >= last_span) mem_wr(wpos + i - last_span, ZERO);
			append_byte(HDR_MARK);
			append_byte(rec_len);
			last_span = len + 3;
			if (wpos + len + 4 > REGION) begin
				wipe_store();
				wpos = 0;
				append_byte(HDR_MARK);
				append_byte(rec_len);
			end
			fill_sum = 8'd0;
			if (len == 0) begin
				append_byte(ZERO);
				return 1'b1;
			end
		end else begin
			len = int'(mem_rd(wpos - fill_cnt - 1));
		end
		append_byte(din);
		fill_sum += din;
		fill_cnt++;
		if (fill_cnt >= len) begin
			append_byte(fill_sum);
			fill_cnt = 0;
			fill_sum = 8'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t o;
		int s, l;
		logic [7:0] sum;
		o = '0;
		if (w.cmd == CMD_NOP) return o;
		if (!pos_found) locate_record();
		case (w.cmd)
			CMD_PUSH: begin
				window_ok = 1'b0;
				o.committed = push_byte(w.data_in);
			end
			CMD_CHECK: begin
				window_ok = 1'b0;
				if (wpos < last_span) o.status = ST_BAD_HDR;
				else begin
					s = wpos - last_span;
					if (mem_rd(s) != HDR_MARK) o.status = ST_BAD_HDR;
					else begin
						l = int'(mem_rd(s + 1));
						o.stored_length = l[7:0];
						sum = 8'd0;
						for (int i = 0; i < l; i++) sum += mem_rd(s + 2 + i);
						if (sum != mem_rd(s + 2 + l)) o.status = ST_BAD_SUM;
						else begin
							window_ok = 1'b1;
							window_base = s + 2;
							window_len = l;
							last_span = l + 3;
						end
					end
				end
			end
			default: begin
				if (!window_ok || int'(w.byte_index) >= window_len) o.status = ST_NO_DATA;
				else o.data_out = mem_rd(window_base + int'(w.byte_index));
			end
		endcase
		return o;
	endfunction

	// Directed rows: stimulus, typed expectation and whether it is typed in.
	in_word_t  dir_in   [DIR_ROWS];
	out_word_t dir_out  [DIR_ROWS];
	bit        dir_typed[DIR_ROWS];

	initial begin
		// read and check before anything was written: nothing to pull
		dir_in[0]  = '{CMD_READ, 8'h00, 8'h00};   dir_out[0]  = '{8'h00, ST_NO_DATA, 1'b0, 8'h00};
		dir_in[1]  = '{CMD_CHECK, 8'h00, 8'h00};  dir_out[1]  = '{8'h00, ST_BAD_HDR, 1'b0, 8'h00};
		dir_in[2]  = '{CMD_NOP, 8'hFF, 8'hFE};    dir_out[2]  = '0;
		// one-byte record, then check and read it back
		dir_in[3]  = '{CMD_PUSH, 8'hFF, 8'h00};   dir_out[3]  = '{8'h00, ST_OK, 1'b1, 8'h00};
		dir_in[4]  = '{CMD_CHECK, 8'h00, 8'hFF};  dir_out[4]  = '{8'h00, ST_OK, 1'b0, 8'h01};
		dir_in[5]  = '{CMD_READ, 8'h00, 8'h00};   dir_out[5]  = '{8'hFF, ST_OK, 1'b0, 8'h00};
		dir_in[6]  = '{CMD_READ, 8'h00, 8'h01};   dir_out[6]  = '{8'h00, ST_NO_DATA, 1'b0, 8'h00};
		dir_in[7]  = '{CMD_READ, 8'h00, 8'hFE};   dir_out[7]  = '{8'h00, ST_NO_DATA, 1'b0, 8'h00};
		dir_in[8]  = '{CMD_PUSH, 8'h00, 8'hFE};   dir_out[8]  = '{8'h00, ST_OK, 1'b1, 8'h00};
		// a push drops the pull window
		dir_in[9]  = '{CMD_READ, 8'h00, 8'h00};   dir_out[9]  = '{8'h00, ST_NO_DATA, 1'b0, 8'h00};
		dir_in[10] = '{CMD_CHECK, 8'h00, 8'h00};  dir_out[10] = '{8'h00, ST_OK, 1'b0, 8'h01};
		dir_in[11] = '{CMD_READ, 8'hAA, 8'h00};   dir_out[11] = '{8'h00, ST_OK, 1'b0, 8'h00};
		dir_in[12] = '{CMD_NOP, 8'h55, 8'h55};    dir_out[12] = '0;
		dir_in[13] = '{CMD_PUSH, 8'h5A, 8'hA5};   dir_out[13] = '{8'h00, ST_OK, 1'b1, 8'h00};
		for (int i = 0; i < DIR_ROWS; i++) dir_typed[i] = 1'b1;
	end

	// Receiver: stall on a rotating pattern, with calm stretches.
	logic [15:0] stall_pat = 16'b1011_0010_0000_1110;
	int          rx_phase = 0;
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (rx_phase[9]) result_ready <= 1'b1;
		else result_ready <= stall_pat[rx_phase[3:0]] | ($urandom_range(0, 3) == 0);
	end

	// Checker: compare each word with the typed row or the oldest prediction.
	always @(posedge clk) begin
		out_word_t e;
		out_word_t t;
		if (result_valid && result_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, result);
				n_fail++;
			end else begin
				e = pending_words.pop_front();
				t = typed_word.pop_front();
				if (typed_flag.pop_front()) e = t;
				if (result.data_out !== e.data_out)
					$display("%0t: data_out expected %h actual %h", $time, e.data_out,
						result.data_out);
				if (result.status !== e.status)
					$display("%0t: status expected %0d actual %0d", $time, e.status,
						result.status);
				if (result.committed !== e.committed)
					$display("%0t: committed expected %0d actual %0d", $time, e.committed,
						result.committed);
				if (result.stored_length !== e.stored_length)
					$display("%0t: stored_length expected %h actual %h", $time,
						e.stored_length, result.stored_length);
				if (result !== e) n_fail++;
			end
		end
	end

	// Watchdog: cycles without any accepted word.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
		    (cfg_valid && cfg_ready) || !arst_n || all_sent)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("FAIL flash_record_log_store_core");
			$finish;
		end
	end

	task automatic send_word(in_word_t w, out_word_t typed, bit has_typed);
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		pending_words.push_back(predict_word(w));
		typed_word.push_back(typed);
		typed_flag.push_back(has_typed);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_length(logic [7:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rec_len = v;
	endtask

	function automatic in_word_t random_word(int push_bias);
		in_word_t w;
		int r;
		w.data_in = 8'($urandom_range(0, 255));
		w.byte_index = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254))
			: 8'($urandom_range(0, int'(rec_len)));
		r = $urandom_range(0, 99);
		if (r < push_bias) w.cmd = CMD_PUSH;
		else if (r < push_bias + 10) w.cmd = CMD_CHECK;
		else if (r < 98) w.cmd = CMD_READ;
		else w.cmd = CMD_NOP;
		return w;
	endfunction

	initial begin
		int burst, lengths [6];
		lengths = '{255, 0, 7, 1, 3, 20};
		for (int i = 0; i < REGION; i++) mem[i] = ERASED;
		wpos = 0; pos_found = 1'b0; last_span = 0; fill_cnt = 0; fill_sum = 8'd0;
		window_ok = 1'b0; window_base = 0; window_len = 0; rec_len = 8'd1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_word(dir_in[i], dir_out[i], dir_typed[i]);
			if ($urandom_range(0, 2) == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
		end
		// hold off until every word is back
		wait_drained();

		// Each phase sets a length, then streams mostly full records with checks/reads.
		foreach (lengths[ph]) begin
			write_length(8'(lengths[ph]));
			for (int n = 0; n < ((lengths[ph] > 100) ? 100 : 45); ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++) begin
					send_word(random_word((fill_cnt != 0) ? 85 : 50),
						out_word_t'('0), 1'b0);
					n++;
				end
				if ($urandom_range(0, 1)) begin
					item_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			// finish the open record so the next length starts cleanly
			while (fill_cnt != 0)
				send_word('{CMD_PUSH, 8'($urandom_range(0, 255)), 8'h00},
					out_word_t'('0), 1'b0);
			send_word('{CMD_CHECK, 8'h00, 8'h00}, out_word_t'('0), 1'b0);
			wait_drained();
		end

		all_sent = 1'b1;
		repeat (2000) @(posedge clk);
		if (n_fail == 0 && pending_words.size() == 0)
			$display("PASS flash_record_log_store_core");
		else
			$display("FAIL flash_record_log_store_core");
		$finish;
	end

endmodule
